>>> sv/radar_elevation_below_search_assert.svh
// assertion macros shared by the elevation search checker
`ifndef RADAR_ELEVATION_BELOW_SEARCH_ASSERT_SVH
`define RADAR_ELEVATION_BELOW_SEARCH_ASSERT_SVH

// same-cycle implication, held off during reset
`define REBS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rebs assertion failed");

// next-cycle implication, held off during reset
`define REBS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rebs assertion failed");

`endif

>>> sv/rebs_pkg.sv
// shared widths, codes and constants of the elevation search block
`default_nettype none
package rebs_pkg;

    // field widths fixed by the interface
    localparam int RANGE_W    = 24;
    localparam int HEIGHT_W   = 24;
    localparam int SEC_W      = 18;
    localparam int SPACE_W    = 16;
    localparam int GCNT_W     = 11;
    localparam int ECNT_W     = 5;
    localparam int ELEVIN_W   = 5;
    localparam int GATEIN_W   = 10;
    localparam int MODE_W     = 2;
    localparam int ELEVOUT_W  = 6;
    localparam int STATUS_W   = 2;
    localparam int CFGIDX_W   = 2;
    localparam int CFGDAT_W   = 24;

    // serial arithmetic
    localparam int PROD_W     = RANGE_W + SEC_W;
    localparam int SEC_FRAC   = 16;
    localparam int SLANT_W    = PROD_W - SEC_FRAC;
    localparam int MUL_STEPS  = SEC_W;
    localparam int DIV_STEPS  = SLANT_W;
    localparam int STEP_CNT_W = 5;

    // input word modes
    localparam logic [MODE_W-1:0] MODE_SEC   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BEAM  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_FOUND = 2'd0;
    localparam logic [STATUS_W-1:0] ST_GATE  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BELOW = 2'd2;
    localparam logic [STATUS_W-1:0] ST_ABOVE = 2'd3;

    // no elevation below, all ones
    localparam logic [ELEVOUT_W-1:0] ELEV_NONE = '1;

    // configuration register indexes
    localparam logic [CFGIDX_W-1:0] CFG_START_RANGE  = 2'd0;
    localparam logic [CFGIDX_W-1:0] CFG_GATE_SPACING = 2'd1;
    localparam logic [CFGIDX_W-1:0] CFG_GATE_COUNT   = 2'd2;
    localparam logic [CFGIDX_W-1:0] CFG_ELEV_COUNT   = 2'd3;

    // configuration reset values
    localparam logic [RANGE_W-1:0] START_RANGE_RST  = 24'd0;
    localparam logic [SPACE_W-1:0] GATE_SPACING_RST = 16'd256;
    localparam logic [GCNT_W-1:0]  GATE_COUNT_RST   = 11'd1024;
    localparam logic [ECNT_W-1:0]  ELEV_COUNT_RST   = 5'd0;

endpackage
`default_nettype wire

>>> sv/rebs_mul.sv
// bit-serial shift-add multiplier, range times secant
`default_nettype none
module rebs_mul (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [rebs_pkg::RANGE_W-1:0]  i_mcand,
    input  wire logic [rebs_pkg::SEC_W-1:0]    i_mplier,
    output logic                               o_done,
    output logic [rebs_pkg::PROD_W-1:0]        o_product
);

    logic                               r_busy;
    logic                               r_done;
    logic [rebs_pkg::STEP_CNT_W-1:0]    r_cnt;
    logic [rebs_pkg::RANGE_W-1:0]       r_mcand;
    logic [rebs_pkg::SEC_W-1:0]         r_mpl;
    logic [rebs_pkg::PROD_W-1:0]        r_acc;
    logic [rebs_pkg::RANGE_W:0]         n_sum;

    // add the multiplicand into the top of the accumulator when the low bit is set
    assign n_sum = {1'b0, r_acc[rebs_pkg::PROD_W-1:rebs_pkg::SEC_W]}
                 + (r_mpl[0] ? {1'b0, r_mcand} : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == rebs_pkg::STEP_CNT_W'(rebs_pkg::MUL_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mcand <= i_mcand;
            r_mpl   <= i_mplier;
            r_acc   <= '0;
        end else if (r_busy) begin
            r_acc <= {n_sum, r_acc[rebs_pkg::SEC_W-1:1]};
            r_mpl <= r_mpl >> 1;
        end
    end

    assign o_done    = r_done;
    assign o_product = r_acc;

endmodule
`default_nettype wire

>>> sv/rebs_div.sv
// bit-serial restoring divider, range offset over gate spacing
`default_nettype none
module rebs_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [rebs_pkg::SLANT_W-1:0]  i_dividend,
    input  wire logic [rebs_pkg::SPACE_W-1:0]  i_divisor,
    output logic                               o_done,
    output logic [rebs_pkg::SLANT_W-1:0]       o_quotient
);

    logic                               r_busy;
    logic                               r_done;
    logic [rebs_pkg::STEP_CNT_W-1:0]    r_cnt;
    logic [rebs_pkg::SPACE_W-1:0]       r_div;
    logic [rebs_pkg::SPACE_W-1:0]       r_rem;
    logic [rebs_pkg::SLANT_W-1:0]       r_q;
    logic [rebs_pkg::SPACE_W:0]         n_trial;
    logic [rebs_pkg::SPACE_W:0]         n_diff;
    logic                               n_ge;

    assign n_trial = {r_rem, r_q[rebs_pkg::SLANT_W-1]};
    assign n_ge    = n_trial >= {1'b0, r_div};
    assign n_diff  = n_trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == rebs_pkg::STEP_CNT_W'(rebs_pkg::DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // remainder stays below the divisor, so 16 bits hold it
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div <= i_divisor;
            r_rem <= '0;
            r_q   <= i_dividend;
        end else if (r_busy) begin
            r_rem <= n_ge ? n_diff[rebs_pkg::SPACE_W-1:0] : n_trial[rebs_pkg::SPACE_W-1:0];
            r_q   <= {r_q[rebs_pkg::SLANT_W-2:0], n_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule
`default_nettype wire

>>> sv/rebs_tables.sv
// secant and beam height memories with registered reads
`default_nettype none
module rebs_tables #(
    parameter int MAX_ELEVATIONS = 32,
    parameter int MAX_GATES      = 1024,
    parameter int EW             = $clog2(MAX_ELEVATIONS),
    parameter int AW             = $clog2(MAX_ELEVATIONS * MAX_GATES)
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_sec_we,
    input  wire logic [EW-1:0]                        i_sec_waddr,
    input  wire logic [rebs_pkg::SEC_W-1:0]           i_sec_wdata,
    input  wire logic [EW-1:0]                        i_sec_raddr,
    output logic [rebs_pkg::SEC_W-1:0]                o_sec_rdata,
    input  wire logic                                 i_beam_we,
    input  wire logic [AW-1:0]                        i_beam_waddr,
    input  wire logic signed [rebs_pkg::HEIGHT_W-1:0] i_beam_wdata,
    input  wire logic [AW-1:0]                        i_beam_raddr,
    output logic signed [rebs_pkg::HEIGHT_W-1:0]      o_beam_rdata
);

    localparam int BEAM_DEPTH = MAX_ELEVATIONS * MAX_GATES;

    logic [rebs_pkg::SEC_W-1:0]           r_sec_mem  [MAX_ELEVATIONS];
    logic signed [rebs_pkg::HEIGHT_W-1:0] r_beam_mem [BEAM_DEPTH];
    logic [rebs_pkg::SEC_W-1:0]           r_sec_rdata;
    logic signed [rebs_pkg::HEIGHT_W-1:0] r_beam_rdata;

    always_ff @(posedge i_clk) begin
        if (i_sec_we) begin
            r_sec_mem[i_sec_waddr] <= i_sec_wdata;
        end
        r_sec_rdata <= r_sec_mem[i_sec_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_beam_we) begin
            r_beam_mem[i_beam_waddr] <= i_beam_wdata;
        end
        r_beam_rdata <= r_beam_mem[i_beam_raddr];
    end

    assign o_sec_rdata  = r_sec_rdata;
    assign o_beam_rdata = r_beam_rdata;

endmodule
`default_nettype wire

>>> sv/radar_elevation_below_search.sv
// top level of the elevation below search: loads, walk sequencer, result register
//
// usage
//   input channel (i_valid / o_ready) carries one word per item: mode 0 loads a
//   secant entry, mode 1 loads a beam height entry, mode 2 is a query, mode 3 is
//   taken and dropped. loads finish in the cycle they are taken and give no result
//   a query walks elevations 0 up to elevation_count + 1 (capped at
//   MAX_ELEVATIONS - 1); each one runs the 18-step serial multiplier and the
//   26-step serial divider. ready stays low from the query until its result
//   enters the output register, and the next word can be taken in the same
//   cycle that the result word shows
//   output channel (o_valid / i_ready) gives one word per query: elevation
//   below and a status code. the result sits in an output register, so the
//   next word is taken while an earlier result waits; a finished query holds
//   until that register is free
//   configuration writes (i_cfg_we, i_cfg_index, i_cfg_data) take effect at
//   once; the user must make them only while the block is idle (not enforced)
//   synchronous active-low reset returns the sequencer to idle, drops o_valid
//   and restores the configuration registers; table contents stay unknown until
//   loaded, no clearing pass is made
`default_nettype none
module radar_elevation_below_search #(
    parameter int MAX_ELEVATIONS = 32,
    parameter int MAX_GATES      = 1024
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // input channel
    input  wire logic                                  i_valid,
    output logic                                       o_ready,
    input  wire logic [rebs_pkg::MODE_W-1:0]           i_mode,
    input  wire logic [rebs_pkg::ELEVIN_W-1:0]         i_elev_index,
    input  wire logic [rebs_pkg::GATEIN_W-1:0]         i_gate_index,
    input  wire logic signed [rebs_pkg::HEIGHT_W-1:0]  i_load_value,
    input  wire logic [rebs_pkg::RANGE_W-1:0]          i_ground_range,
    input  wire logic signed [rebs_pkg::HEIGHT_W-1:0]  i_point_height,
    // output channel
    output logic                                       o_valid,
    input  wire logic                                  i_ready,
    output logic signed [rebs_pkg::ELEVOUT_W-1:0]      o_elev_below,
    output logic [rebs_pkg::STATUS_W-1:0]              o_status,
    // configuration port
    input  wire logic                                  i_cfg_we,
    input  wire logic [rebs_pkg::CFGIDX_W-1:0]         i_cfg_index,
    input  wire logic [rebs_pkg::CFGDAT_W-1:0]         i_cfg_data
);

    localparam int EW = $clog2(MAX_ELEVATIONS);
    localparam int GW = $clog2(MAX_GATES);
    localparam int AW = $clog2(MAX_ELEVATIONS * MAX_GATES);
    localparam int LW = $clog2(MAX_ELEVATIONS + 1);
    // compare width for the walk limit, room for elevation_count + 2 as well
    localparam int XW = ((LW > rebs_pkg::ECNT_W + 1) ? LW : rebs_pkg::ECNT_W + 1) + 1;
    localparam int QW = rebs_pkg::SLANT_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SEC,
        S_MULGO,
        S_MUL,
        S_DIFF,
        S_DIV,
        S_GATE,
        S_BEAM,
        S_CMP,
        S_OUT
    } t_state;

    // configuration registers
    logic [rebs_pkg::RANGE_W-1:0]  r_start_range;
    logic [rebs_pkg::SPACE_W-1:0]  r_gate_spacing;
    logic [rebs_pkg::GCNT_W-1:0]   r_gate_count;
    logic [rebs_pkg::ECNT_W-1:0]   r_elev_count;

    // sequencer and query state
    t_state                                r_state;
    logic [LW-1:0]                         r_lev;
    logic [rebs_pkg::RANGE_W-1:0]          r_rng;
    logic signed [rebs_pkg::HEIGHT_W-1:0]  r_z;
    logic                                  r_neg;
    logic [AW-1:0]                         r_baddr;
    logic [rebs_pkg::ELEVOUT_W-1:0]        r_res_elev;
    logic [rebs_pkg::STATUS_W-1:0]         r_res_status;
    logic                                  r_out_valid;
    logic [rebs_pkg::ELEVOUT_W-1:0]        r_out_elev;
    logic [rebs_pkg::STATUS_W-1:0]         r_out_status;

    // datapath wires
    logic                                  n_accept;
    logic                                  n_elev_ok;
    logic                                  n_gate_ok;
    logic                                  n_sec_we;
    logic                                  n_beam_we;
    logic [AW-1:0]                         n_beam_waddr;
    logic [rebs_pkg::SEC_W-1:0]            n_sec_rdata;
    logic signed [rebs_pkg::HEIGHT_W-1:0]  n_beam_rdata;
    logic                                  n_mul_done;
    logic [rebs_pkg::PROD_W-1:0]           n_product;
    logic [QW-1:0]                         n_slant;
    logic [QW-1:0]                         n_start_ext;
    logic                                  n_neg;
    logic [QW-1:0]                         n_mag;
    logic [rebs_pkg::SPACE_W-1:0]          n_spacing;
    logic                                  n_div_done;
    logic [QW-1:0]                         n_quot;
    logic                                  n_gate_oor;
    logic [GW-1:0]                         n_gate;
    logic [AW-1:0]                         n_baddr;
    logic                                  n_hit;
    logic                                  n_last;
    logic                                  n_out_free;

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_range  <= rebs_pkg::START_RANGE_RST;
            r_gate_spacing <= rebs_pkg::GATE_SPACING_RST;
            r_gate_count   <= rebs_pkg::GATE_COUNT_RST;
            r_elev_count   <= rebs_pkg::ELEV_COUNT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                rebs_pkg::CFG_START_RANGE: begin
                    r_start_range <= i_cfg_data[rebs_pkg::RANGE_W-1:0];
                end
                rebs_pkg::CFG_GATE_SPACING: begin
                    r_gate_spacing <= i_cfg_data[rebs_pkg::SPACE_W-1:0];
                end
                rebs_pkg::CFG_GATE_COUNT: begin
                    r_gate_count <= i_cfg_data[rebs_pkg::GCNT_W-1:0];
                end
                rebs_pkg::CFG_ELEV_COUNT: begin
                    r_elev_count <= i_cfg_data[rebs_pkg::ECNT_W-1:0];
                end
            endcase
        end
    end

    // ---------------------------------------------------------------
    // loads: written straight into the tables when the word is taken,
    // addresses past the table size are dropped
    // ---------------------------------------------------------------
    assign o_ready   = (r_state == S_IDLE);
    assign n_accept  = i_valid && o_ready;
    assign n_elev_ok = 32'(i_elev_index) < 32'(MAX_ELEVATIONS);
    assign n_gate_ok = 32'(i_gate_index) < 32'(MAX_GATES);
    assign n_sec_we  = n_accept && (i_mode == rebs_pkg::MODE_SEC) && n_elev_ok;
    assign n_beam_we = n_accept && (i_mode == rebs_pkg::MODE_BEAM) && n_elev_ok && n_gate_ok;

    // row-major: elevation * MAX_GATES + gate
    assign n_beam_waddr = AW'(AW'(EW'(i_elev_index)) * AW'(MAX_GATES)) + AW'(GW'(i_gate_index));

    rebs_tables #(
        .MAX_ELEVATIONS (MAX_ELEVATIONS),
        .MAX_GATES      (MAX_GATES),
        .EW             (EW),
        .AW             (AW)
    ) u_tables (
        .i_clk        (i_clk),
        .i_sec_we     (n_sec_we),
        .i_sec_waddr  (EW'(i_elev_index)),
        .i_sec_wdata  (i_load_value[rebs_pkg::SEC_W-1:0]),
        .i_sec_raddr  (r_lev[EW-1:0]),
        .o_sec_rdata  (n_sec_rdata),
        .i_beam_we    (n_beam_we),
        .i_beam_waddr (n_beam_waddr),
        .i_beam_wdata (i_load_value),
        .i_beam_raddr (r_baddr),
        .o_beam_rdata (n_beam_rdata)
    );

    // ---------------------------------------------------------------
    // slant range: ground range times Q2.16 secant, bit-serial
    // ---------------------------------------------------------------
    rebs_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_state == S_MULGO),
        .i_mcand   (r_rng),
        .i_mplier  (n_sec_rdata),
        .o_done    (n_mul_done),
        .o_product (n_product)
    );

    // offset from the first gate as sign and magnitude, so the divide
    // truncates toward zero on both sides
    assign n_slant     = n_product[rebs_pkg::PROD_W-1:rebs_pkg::SEC_FRAC];
    assign n_start_ext = QW'(r_start_range);
    assign n_neg       = n_slant < n_start_ext;
    assign n_mag       = n_neg ? (n_start_ext - n_slant) : (n_slant - n_start_ext);

    // a zero spacing counts as one
    assign n_spacing = (r_gate_spacing == '0) ? rebs_pkg::SPACE_W'(1) : r_gate_spacing;

    rebs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_DIFF),
        .i_dividend (n_mag),
        .i_divisor  (n_spacing),
        .o_done     (n_div_done),
        .o_quotient (n_quot)
    );

    // ---------------------------------------------------------------
    // gate check: negative offset is legal only when it rounds to zero
    // and some gate is in use, the usable limit is the smaller of
    // gate_count and the table size
    // ---------------------------------------------------------------
    assign n_gate_oor = r_neg ? ((n_quot != '0) || (r_gate_count == '0))
                              : ((n_quot >= QW'(r_gate_count)) || (n_quot >= QW'(MAX_GATES)));
    assign n_gate     = r_neg ? '0 : n_quot[GW-1:0];
    assign n_baddr    = AW'(AW'(r_lev[EW-1:0]) * AW'(MAX_GATES)) + AW'(n_gate);

    // beam above the point ends the walk
    assign n_hit  = r_z < n_beam_rdata;
    assign n_last = ((XW'(r_lev) + XW'(1)) >= XW'(MAX_ELEVATIONS))
                 || ((XW'(r_lev) + XW'(1)) >= (XW'(r_elev_count) + XW'(2)));

    assign n_out_free = !r_out_valid || i_ready;

    // ---------------------------------------------------------------
    // walk sequencer and output register
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_OUT && n_out_free) begin
                r_out_valid  <= 1'b1;
                r_out_elev   <= r_res_elev;
                r_out_status <= r_res_status;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (n_accept && i_mode == rebs_pkg::MODE_QUERY) begin
                        r_lev   <= '0;
                        r_rng   <= i_ground_range;
                        r_z     <= i_point_height;
                        r_state <= S_SEC;
                    end
                end
                S_SEC: begin
                    r_state <= S_MULGO;
                end
                S_MULGO: begin
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    if (n_mul_done) begin
                        r_state <= S_DIFF;
                    end
                end
                S_DIFF: begin
                    r_neg   <= n_neg;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (n_div_done) begin
                        r_state <= S_GATE;
                    end
                end
                S_GATE: begin
                    if (n_gate_oor) begin
                        r_res_elev   <= rebs_pkg::ELEV_NONE;
                        r_res_status <= rebs_pkg::ST_GATE;
                        r_state      <= S_OUT;
                    end else begin
                        r_baddr <= n_baddr;
                        r_state <= S_BEAM;
                    end
                end
                S_BEAM: begin
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (n_hit) begin
                        if (r_lev == '0) begin
                            r_res_elev   <= rebs_pkg::ELEV_NONE;
                            r_res_status <= rebs_pkg::ST_BELOW;
                        end else begin
                            r_res_elev   <= rebs_pkg::ELEVOUT_W'(r_lev - 1'b1);
                            r_res_status <= rebs_pkg::ST_FOUND;
                        end
                        r_state <= S_OUT;
                    end else if (n_last) begin
                        r_res_elev   <= rebs_pkg::ELEV_NONE;
                        r_res_status <= rebs_pkg::ST_ABOVE;
                        r_state      <= S_OUT;
                    end else begin
                        r_lev   <= r_lev + 1'b1;
                        r_state <= S_SEC;
                    end
                end
                S_OUT: begin
                    if (n_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid      = r_out_valid;
    assign o_elev_below = $signed(r_out_elev);
    assign o_status     = r_out_status;

endmodule
`default_nettype wire

>>> sv/rebs_checker.sv
// port-level checker for the elevation below search, bound to the top level
`default_nettype none
`include "radar_elevation_below_search_assert.svh"
module rebs_checker (
    input wire logic                                  i_clk,
    input wire logic                                  i_rst_n,
    input wire logic                                  i_valid,
    input wire logic                                  o_ready,
    input wire logic [rebs_pkg::MODE_W-1:0]           i_mode,
    input wire logic                                  o_valid,
    input wire logic                                  i_ready,
    input wire logic signed [rebs_pkg::ELEVOUT_W-1:0] o_elev_below,
    input wire logic [rebs_pkg::STATUS_W-1:0]         o_status
);

    // a result word waits until taken
    `REBS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid)

    // any status but found carries no elevation
    `REBS_ASSERT_IMPLY(a_none_elev, i_clk, i_rst_n, o_valid && (o_status != rebs_pkg::ST_FOUND), o_elev_below == $signed(rebs_pkg::ELEV_NONE))

    // a query keeps the input side closed while it walks
    `REBS_ASSERT_NEXT(a_query_busy, i_clk, i_rst_n, i_valid && o_ready && (i_mode == rebs_pkg::MODE_QUERY), !o_ready)

    // a new result only appears at the end of a walk
    `REBS_ASSERT_IMPLY(a_result_src, i_clk, i_rst_n, $rose(o_valid), $past(!o_ready))

endmodule

bind radar_elevation_below_search rebs_checker u_rebs_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_ready      (o_ready),
    .i_mode       (i_mode),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_elev_below (o_elev_below),
    .o_status     (o_status)
);
`default_nettype wire
